// ===== design/stip_pkg.sv =====
// Package for the ASCII integer parser: widths, character codes, classified
// byte and configuration types, and small saturation helpers.
// No dependencies.
package stip_pkg;

  localparam int OFFSET_BITS = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SELECT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_MODE = 2'd1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_ONE  = 6'd1;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;
  localparam logic [5:0] BASE_MAX  = 6'd36;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_START  = 3'd1,
    PH_ZERO   = 3'd2,
    PH_XSEEN  = 3'd3,
    PH_DIGITS = 3'd4
  } stip_phase_e;

  typedef struct packed {
    logic [5:0] digit;
    logic       is_digit;
    logic       is_space;
    logic       is_minus;
    logic       is_plus;
    logic       is_zero;
    logic       is_x;
    logic       last;
  } stip_class_t;

  typedef struct packed {
    logic [5:0] base_select;
    logic       signed_mode;
  } stip_cfg_t;

  function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] p);
    return (p == '1) ? p : p + 1'b1;
  endfunction

  function automatic logic [15:0] sat_offset(input logic [OFFSET_BITS-1:0] p);
    logic [OFFSET_BITS+15:0] w;
    w = {16'b0, p};
    return (w[OFFSET_BITS+15:16] != '0) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

// ===== design/stip_if.sv =====
// Channel interfaces of the ASCII integer parser: byte requests, results and
// configuration writes. Depends on stip_pkg.
interface stip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last_byte;
  modport source (output valid, ch, last_byte, input ready);
  modport sink (input valid, ch, last_byte, output ready);
endinterface

interface stip_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [15:0] end_offset;
  logic        is_negative;
  logic        no_digits;
  modport source (output valid, value, end_offset, is_negative, no_digits, input ready);
  modport sink (input valid, value, end_offset, is_negative, no_digits, output ready);
endinterface

interface stip_cfg_if import stip_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/string_to_integer_parser_top.sv =====
// Top level of the ASCII integer parser: configuration registers, front end,
// byte queue and back end. Depends on stip_pkg, stip_if and the stip modules.
//
// The block parses a strtol-style integer from a stream of character bytes.
// Each request on in_i carries one byte and a flag that marks the last byte of
// the string. One result per string leaves on out_o: the value modulo 2^64
// (negated after a minus sign), the end offset, the sign and a no-digit flag.
// Bytes after the parse stops are consumed without a result until the byte
// marked last, which returns the parser to its initial state.
// Configuration writes on cfg_i are always ready; index 0 sets the base and
// index 1 the signed mode. A write is registered and applies to the next
// byte the back end takes, also within a string. Throughput is one byte
// per cycle while out_o is not stalled, set by the single 64 by 6 bit
// multiply-add in the back end, which loads out_o when a number ends.
// Reset clears the parser state, selects automatic base and signed mode and
// empties the queue. While out_o is stalled, bytes that produce no result keep
// flowing; a byte that ends a number waits in the two-entry queue, and in_i
// drops ready once the queue is full.
module string_to_integer_parser_top import stip_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  stip_in_if.sink   in_i,
  stip_out_if.source out_o,
  stip_cfg_if.sink  cfg_i
);

  stip_cfg_t   cfg_q, cfg_d;
  logic        push;
  logic        full;
  stip_class_t front_data;
  logic        head_valid;
  stip_class_t head_data;
  logic        pop;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BASE_SELECT: cfg_d.base_select = cfg_i.data[5:0];
        CFG_SIGNED_MODE: cfg_d.signed_mode = cfg_i.data[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_select <= BASE_AUTO;
      cfg_q.signed_mode <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  stip_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .data_o (front_data)
  );

  stip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_data),
    .full_o  (full),
    .valid_o (head_valid),
    .data_o  (head_data),
    .pop_i   (pop)
  );

  stip_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_data),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .out_o        (out_o)
  );

endmodule

// ===== design/stip_front.sv =====
// Front end: accepts byte requests and classifies each character.
// Depends on stip_pkg and stip_if.
module stip_front import stip_pkg::*; (
  stip_in_if.sink     in_i,
  input  logic        full_i,
  output logic        push_o,
  output stip_class_t data_o
);

  logic [7:0] dig_num;
  logic [7:0] dig_low;
  logic [7:0] dig_up;
  logic       in_num;
  logic       in_low;
  logic       in_up;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign dig_num = in_i.ch - CH_0;
  assign dig_low = in_i.ch - CH_LA + 8'd10;
  assign dig_up  = in_i.ch - CH_UA + 8'd10;
  assign in_num  = (in_i.ch >= CH_0) && (in_i.ch <= CH_9);
  assign in_low  = (in_i.ch >= CH_LA) && (in_i.ch <= CH_LZ);
  assign in_up   = (in_i.ch >= CH_UA) && (in_i.ch <= CH_UZ);

  always_comb begin
    data_o.digit    = in_num ? dig_num[5:0] : (in_low ? dig_low[5:0] : dig_up[5:0]);
    data_o.is_digit = in_num || in_low || in_up;
    data_o.is_space = (in_i.ch == CH_SPACE) || ((in_i.ch >= CH_TAB) && (in_i.ch <= CH_CR));
    data_o.is_minus = (in_i.ch == CH_MINUS);
    data_o.is_plus  = (in_i.ch == CH_PLUS);
    data_o.is_zero  = (in_i.ch == CH_0);
    data_o.is_x     = (in_i.ch == CH_LX) || (in_i.ch == CH_UX);
    data_o.last     = in_i.last_byte;
  end

endmodule

// ===== design/stip_queue.sv =====
// Two-entry queue of classified bytes between the front and back ends.
// Depends on stip_pkg.
module stip_queue import stip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  stip_class_t data_i,
  output logic        full_o,
  output logic        valid_o,
  output stip_class_t data_o,
  input  logic        pop_i
);

  stip_class_t mem_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/stip_back.sv =====
// Back end: runs the parse state machine with one multiply-add per byte and
// holds the result register. Depends on stip_pkg and stip_if.
module stip_back import stip_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  stip_class_t head_i,
  output logic        pop_o,
  input  stip_cfg_t   cfg_i,
  stip_out_if.source  out_o
);

  stip_phase_e            phase_q, phase_d, upd_phase;
  logic [63:0]            acc_q, acc_d, upd_acc;
  logic                   minus_q, minus_d, upd_minus;
  logic [5:0]             base_q, base_d, upd_base;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] dend_q, dend_d, upd_dend;
  logic                   sent_q, sent_d, upd_sent;

  logic                   stop;
  logic                   run_start;
  logic                   run_digits;
  logic [5:0]             dbase;
  logic [69:0]            mul_full;
  logic                   emit;
  logic                   out_free;
  logic                   load;

  logic                   ovalid_q, ovalid_d;
  logic [63:0]            oval_q;
  logic                   oneg_q;
  logic [15:0]            oend_q;
  logic                   onone_q;

  assign mul_full = acc_q * dbase;

  always_comb begin
    upd_phase  = phase_q;
    upd_acc    = acc_q;
    upd_minus  = minus_q;
    upd_base   = base_q;
    upd_dend   = dend_q;
    upd_sent   = sent_q;
    stop       = 1'b0;
    run_start  = 1'b0;
    run_digits = 1'b0;
    dbase      = base_q;

    if (!sent_q) begin
      unique case (phase_q)
        PH_SPACE: begin
          if (head_i.is_space) begin
            upd_phase = PH_SPACE;
          end else if (cfg_i.signed_mode && head_i.is_minus) begin
            upd_minus = 1'b1;
            upd_phase = PH_START;
          end else if (head_i.is_plus) begin
            upd_phase = PH_START;
          end else begin
            run_start = 1'b1;
          end
        end
        PH_START: run_start = 1'b1;
        PH_ZERO: begin
          if (head_i.is_x) begin
            upd_base  = BASE_HEX;
            upd_phase = PH_XSEEN;
          end else begin
            run_digits = 1'b1;
          end
        end
        PH_XSEEN: begin
          if (head_i.is_digit && (head_i.digit < BASE_HEX)) begin
            run_digits = 1'b1;
          end else begin
            stop = 1'b1;
          end
        end
        PH_DIGITS: run_digits = 1'b1;
        default: stop = 1'b1;
      endcase

      if (run_start) begin
        if ((cfg_i.base_select == BASE_ONE) || (cfg_i.base_select > BASE_MAX)) begin
          stop = 1'b1;
        end else if (((cfg_i.base_select == BASE_AUTO) || (cfg_i.base_select == BASE_HEX))
                     && head_i.is_zero) begin
          upd_base  = (cfg_i.base_select == BASE_AUTO) ? BASE_OCT : BASE_HEX;
          upd_dend  = sat_inc(pos_q);
          upd_phase = PH_ZERO;
        end else begin
          upd_base   = (cfg_i.base_select == BASE_AUTO) ? BASE_DEC : cfg_i.base_select;
          run_digits = 1'b1;
        end
      end

      if (run_digits) begin
        dbase     = upd_base;
        upd_phase = PH_DIGITS;
        if (head_i.is_digit && (head_i.digit < upd_base)) begin
          upd_acc  = mul_full[63:0] + {58'b0, head_i.digit};
          upd_dend = sat_inc(pos_q);
        end else begin
          stop = 1'b1;
        end
      end

      if (stop && !head_i.last) begin
        upd_sent = 1'b1;
      end
    end

    if (head_i.last) begin
      phase_d = PH_SPACE;
      acc_d   = '0;
      minus_d = 1'b0;
      base_d  = '0;
      pos_d   = '0;
      dend_d  = '0;
      sent_d  = 1'b0;
    end else begin
      phase_d = upd_phase;
      acc_d   = upd_acc;
      minus_d = upd_minus;
      base_d  = upd_base;
      pos_d   = sat_inc(pos_q);
      dend_d  = upd_dend;
      sent_d  = upd_sent;
    end
  end

  always_comb begin
    emit     = !sent_q && (stop || head_i.last);
    out_free = !ovalid_q || out_o.ready;
    pop_o    = head_valid_i && (!emit || out_free);
    load     = pop_o && emit;
    ovalid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SPACE;
      acc_q    <= '0;
      minus_q  <= 1'b0;
      base_q   <= '0;
      pos_q    <= '0;
      dend_q   <= '0;
      sent_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= ovalid_d;
      if (pop_o) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        minus_q <= minus_d;
        base_q  <= base_d;
        pos_q   <= pos_d;
        dend_q  <= dend_d;
        sent_q  <= sent_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      oval_q  <= (upd_dend == '0) ? 64'd0 : upd_acc;
      oneg_q  <= upd_minus;
      oend_q  <= sat_offset(upd_dend);
      onone_q <= (upd_dend == '0);
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.value       = oneg_q ? (64'd0 - oval_q) : oval_q;
  assign out_o.end_offset  = oend_q;
  assign out_o.is_negative = oneg_q;
  assign out_o.no_digits   = onone_q;

endmodule

// ===== design/stip_checker.sv =====
// Port-level checks on the result channel of the ASCII integer parser,
// attached to the top level by a bind statement. No package dependency.
module stip_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] out_value_i,
  input logic [15:0] out_end_offset_i,
  input logic        out_no_digits_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result request dropped while stalled");

  a_value_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i))
    else $error("result value changed while stalled");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_no_digits_i |-> (out_value_i == 64'd0) && (out_end_offset_i == 16'd0))
    else $error("result without digits carries a value or offset");

  a_digit_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_no_digits_i |-> (out_end_offset_i != 16'd0))
    else $error("result with digits has a zero end offset");

endmodule

bind string_to_integer_parser_top stip_checker u_stip_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_value_i      (out_o.value),
  .out_end_offset_i (out_o.end_offset),
  .out_no_digits_i  (out_o.no_digits)
);

// ===== tb/parse_check_pkg.sv =====
// Result predictor and scoreboard for the ASCII integer parser testbench.
// Depends on stip_pkg for widths, character codes and parser phases.
package parse_check_pkg;
  import stip_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam int NO_DIGIT = 99;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    logic [63:0] value;
    logic [15:0] end_offset;
    logic        is_negative;
    logic        no_digits;
  } parsed_number_t;

  class parse_checker;
    logic [5:0]             base_cfg = BASE_AUTO;
    bit                     signed_cfg = 1'b1;
    stip_phase_e            ph;
    logic [63:0]            acc;
    bit                     neg;
    logic [5:0]             radix;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic [OFFSET_BITS-1:0] dig_end;
    bit                     sent;
    parsed_number_t         awaited[$];
    int                     failures;

    function new();
      failures = 0;
      restart();
    endfunction

    function void restart();
      ph = PH_SPACE;
      acc = '0;
      neg = 1'b0;
      radix = '0;
      byte_pos = '0;
      dig_end = '0;
      sent = 1'b0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_BASE_SELECT) begin
        base_cfg = data[5:0];
      end else if (index == CFG_SIGNED_MODE) begin
        signed_cfg = data[0];
      end
    endfunction

    function logic [OFFSET_BITS-1:0] bump(logic [OFFSET_BITS-1:0] p);
      return (&p) ? p : p + 1'b1;
    endfunction

    function int digit_value(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
      return NO_DIGIT;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR ||
             c == CH_FF || c == CH_VT;
    endfunction

    // Returns 0 when the byte only runs out a string whose result has gone.
    function bit note_byte(logic [7:0] c, logic last);
      logic [OFFSET_BITS-1:0] at;
      bit                     stop;
      bit                     again;
      int                     d;
      parsed_number_t         r;
      at = byte_pos;
      stop = 1'b0;
      again = 1'b1;
      if (sent) begin
        if (last) restart();
        return 1'b0;
      end
      while (again) begin
        again = 1'b0;
        case (ph)
          PH_SPACE: begin
            if (!is_blank(c)) begin
              if (signed_cfg && c == CH_MINUS) begin
                neg = 1'b1;
                ph = PH_START;
              end else if (c == CH_PLUS) begin
                ph = PH_START;
              end else begin
                ph = PH_START;
                again = 1'b1;
              end
            end
          end
          PH_START: begin
            if (base_cfg == BASE_ONE || base_cfg > BASE_MAX) begin
              stop = 1'b1;
            end else if ((base_cfg == BASE_AUTO || base_cfg == BASE_HEX) && c == CH_0) begin
              radix = (base_cfg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
              dig_end = bump(at);
              ph = PH_ZERO;
            end else begin
              radix = (base_cfg == BASE_AUTO) ? BASE_DEC : base_cfg;
              ph = PH_DIGITS;
              again = 1'b1;
            end
          end
          PH_ZERO: begin
            if (c == CH_LX || c == CH_UX) begin
              radix = BASE_HEX;
              ph = PH_XSEEN;
            end else begin
              ph = PH_DIGITS;
              again = 1'b1;
            end
          end
          PH_XSEEN: begin
            if (digit_value(c) < int'(BASE_HEX)) begin
              ph = PH_DIGITS;
              again = 1'b1;
            end else begin
              stop = 1'b1;
            end
          end
          PH_DIGITS: begin
            d = digit_value(c);
            if (d < int'(radix)) begin
              acc = acc * 64'(radix) + 64'(d);
              dig_end = bump(at);
            end else begin
              stop = 1'b1;
            end
          end
          default: begin
            stop = 1'b1;
          end
        endcase
      end
      byte_pos = bump(at);
      if (!stop && !last) return 1'b1;
      r.no_digits = (dig_end == '0);
      r.value = r.no_digits ? 64'd0 : acc;
      if (neg) r.value = 64'd0 - r.value;
      r.end_offset = (32'(dig_end) > 32'hFFFF) ? 16'hFFFF : 16'(dig_end);
      r.is_negative = neg;
      awaited.push_back(r);
      if (last) restart();
      else sent = 1'b1;
      return 1'b1;
    endfunction

    function void check_result(logic [63:0] value, logic [15:0] end_offset,
                               logic is_negative, logic no_digits);
      parsed_number_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, value %h end_offset %0d", $time, value, end_offset);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (want.value !== value) begin
        $display("%0t: value expected %h actual %h", $time, want.value, value);
        failures++;
      end
      if (want.end_offset !== end_offset) begin
        $display("%0t: end_offset expected %0d actual %0d", $time, want.end_offset,
                 end_offset);
        failures++;
      end
      if (want.is_negative !== is_negative) begin
        $display("%0t: is_negative expected %b actual %b", $time, want.is_negative,
                 is_negative);
        failures++;
      end
      if (want.no_digits !== no_digits) begin
        $display("%0t: no_digits expected %b actual %b", $time, want.no_digits, no_digits);
        failures++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

endpackage

// ===== tb/string_to_integer_parser_top_tb.sv =====
// Testbench top for the ASCII integer parser: directed and random strings,
// random idling on both channels, back-pressure and register sweeps.
// Depends on stip_pkg, stip_if, parse_check_pkg and the parser RTL.
module string_to_integer_parser_top_tb;
  import stip_pkg::*;
  import parse_check_pkg::*;

  localparam int ITEMS = 1150;
  localparam int STRINGS_PER_PHASE = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int STALL_LIMIT = 4000;
  localparam logic [5:0] BASE_MIN = 6'd2;
  localparam logic [5:0] BASE_TOP = 6'd63;

  logic clk_i = 1'b0;
  logic rst_ni;

  stip_in_if  byte_if();
  stip_out_if res_if();
  stip_cfg_if cfg_if();

  string_to_integer_parser_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  parse_checker sb = new();

  int         src_gap_pct = 26;
  int         sink_gap_pct = 26;
  bit         hold_results = 1'b0;
  int         bytes_parsed = 0;
  logic [5:0] cur_base = BASE_AUTO;
  logic [7:0] text[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_results) begin
        res_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_results = 1'b0;
      end
      res_if.ready = ($urandom_range(99) >= sink_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      sb.check_result(res_if.value, res_if.end_offset, res_if.is_negative, res_if.no_digits);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < src_gap_pct) begin
      byte_if.valid = 1'b0;
      byte_if.ch = 8'($urandom);
      byte_if.last_byte = 1'($urandom);
      @(negedge clk_i);
    end
    byte_if.valid = 1'b1;
    byte_if.ch = c;
    byte_if.last_byte = last;
    do @(posedge clk_i); while (!byte_if.ready);
    void'(sb.note_byte(c, last));
    bytes_parsed++;
    @(negedge clk_i);
  endtask

  task automatic send_string();
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic drain();
    byte_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = index;
    cfg_if.data = data;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_register(index, data);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic set_config(input logic [5:0] base, input bit sgn);
    write_reg(CFG_BASE_SELECT, {2'($urandom), base});
    write_reg(CFG_SIGNED_MODE, {7'($urandom), sgn});
    if ($urandom_range(2) == 0) begin
      write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 8'($urandom));
    end
    cur_base = base;
  endtask

  function automatic void load(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_CR;
      4: return CH_FF;
      default: return CH_VT;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(int'(CH_0) + d);
    return 8'(int'($urandom_range(1) ? CH_LA : CH_UA) + d - 10);
  endfunction

  task automatic build_number();
    int radix;
    int n_dig;
    int ending;
    text.delete();
    repeat ($urandom_range(2)) text.push_back(blank_char());
    case ($urandom_range(2))
      1: text.push_back(CH_PLUS);
      2: text.push_back(CH_MINUS);
      default: ;
    endcase
    radix = (cur_base == BASE_AUTO || cur_base == BASE_ONE || cur_base > BASE_MAX) ?
            10 : int'(cur_base);
    if (cur_base == BASE_AUTO || cur_base == BASE_HEX) begin
      case ($urandom_range(3))
        1: begin
          text.push_back(CH_0);
          if (cur_base == BASE_AUTO) radix = 8;
        end
        2: begin
          text.push_back(CH_0);
          text.push_back(CH_LX);
          radix = 16;
        end
        3: begin
          text.push_back(CH_0);
          text.push_back(CH_UX);
          radix = 16;
        end
        default: ;
      endcase
    end
    n_dig = ($urandom_range(7) == 0) ? $urandom_range(24, 12) : $urandom_range(5);
    repeat (n_dig) text.push_back(digit_char($urandom_range(radix - 1)));
    ending = $urandom_range(2);
    if (ending == 1) text.push_back(CH_NUL);
    if (ending == 2) text.push_back(8'($urandom));
    if (ending != 0) begin
      repeat ($urandom_range(3)) text.push_back(8'($urandom));
    end
    if (text.size() == 0) text.push_back(8'($urandom));
  endtask

  initial begin
    int         phase_no;
    logic [5:0] pick;
    bit         sgn;
    rst_ni = 1'b0;
    byte_if.valid = 1'b0;
    byte_if.ch = '0;
    byte_if.last_byte = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    load("\t-0x1Fg");
    send_string();
    load("0x");
    text.push_back(8'hFF);
    send_string();
    load("+");
    text.push_back(CH_NUL);
    send_string();
    load("-");
    text.push_back(CH_NUL);
    send_string();
    load("017");
    send_string();
    load("95");
    text.insert(1, CH_NUL);
    send_string();
    drain();
    set_config(BASE_MAX, 1'b0);
    load("-z");
    send_string();
    drain();
    set_config(BASE_ONE, 1'b1);
    load(" 5");
    send_string();

    bytes_parsed = 0;
    phase_no = 0;
    while (bytes_parsed < ITEMS) begin
      drain();
      case (phase_no)
        0: begin pick = BASE_AUTO; sgn = 1'b1; end
        1: begin pick = BASE_MAX;  sgn = 1'b0; end
        2: begin pick = BASE_MIN;  sgn = 1'b1; end
        3: begin pick = BASE_HEX;  sgn = 1'b0; end
        4: begin pick = BASE_TOP;  sgn = 1'b1; end
        5: begin pick = BASE_DEC;  sgn = 1'b0; end
        default: begin
          case ($urandom_range(9))
            0: pick = BASE_AUTO;
            1: pick = BASE_HEX;
            2: pick = BASE_OCT;
            3: pick = BASE_DEC;
            4: pick = BASE_ONE;
            5: pick = 6'($urandom_range(63, 37));
            default: pick = 6'($urandom_range(36, 2));
          endcase
          sgn = 1'($urandom);
        end
      endcase
      set_config(pick, sgn);
      src_gap_pct = (phase_no == 3 || phase_no == 5) ? 0 : 26;
      sink_gap_pct = (phase_no == 3) ? 0 : 26;
      if (phase_no == 5) hold_results = 1'b1;
      repeat (STRINGS_PER_PHASE) begin
        if ($urandom_range(99) < 80) begin
          build_number();
        end else begin
          text.delete();
          repeat ($urandom_range(6, 1)) text.push_back(8'($urandom));
        end
        send_string();
      end
      phase_no++;
    end

    byte_if.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
